[src/b64_pkg.sv]
// b64_pkg: shared types, constants and the sextet-to-character map for the
// Base64 stream encoder. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package b64_pkg;

	localparam int BYTE_W      = 8;
	localparam int COL_W       = 10;
	localparam int CFG_DATA_W  = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int JOB_CHARS   = 5;
	localparam int JOB_CNT_W   = 3;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [BYTE_W-1:0] NEWLINE_CHAR   = 8'h0A;
	localparam logic [BYTE_W-1:0] RST_CHAR_62    = 8'd43;
	localparam logic [BYTE_W-1:0] RST_CHAR_63    = 8'd47;
	localparam logic [BYTE_W-1:0] RST_PAD_CHAR   = 8'd61;
	localparam logic [COL_W-1:0]  RST_LINE_LEN   = '0;
	localparam logic [COL_W-1:0]  COLUMN_MAX     = 10'd1023;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHAR_62  = 2'd0,
		CFG_CHAR_63  = 2'd1,
		CFG_PAD_CHAR = 2'd2,
		CFG_LINE_LEN = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] char_62;
		logic [BYTE_W-1:0] char_63;
		logic [BYTE_W-1:0] pad_char;
		logic [COL_W-1:0]  line_length;
	} cfg_t;

	// Characters caused by one input byte, in output order.
	typedef struct packed {
		logic [JOB_CHARS-1:0][BYTE_W-1:0] chars;
		logic [JOB_CNT_W-1:0]             cnt;
		logic                             last;
	} job_t;

	function automatic logic [BYTE_W-1:0] sextet_char(input logic [5:0] v,
			input logic [BYTE_W-1:0] c62, input logic [BYTE_W-1:0] c63);
		logic [BYTE_W-1:0] r;
		r = '0;
		if (v < 6'd26) begin
			r = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'd97 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = 8'd48 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = c62;
		end else begin
			r = c63;
		end
		return r;
	endfunction

endpackage

[src/b64_if.sv]
// b64_byte_if / b64_char_if: valid/ready channels for raw bytes and for
// encoded characters. Depends on b64_pkg.
`timescale 1ns / 1ps

interface b64_byte_if import b64_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64_char_if import b64_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_char;
	logic              run_end;
	logic              stream_end;

	modport source (output valid, output out_char, output run_end, output stream_end,
		input ready);
	modport sink   (input valid, input out_char, input run_end, input stream_end,
		output ready);
endinterface

[src/base64_stream_encoder_top.sv]
// base64_stream_encoder_top: Base64 encoder with configurable symbols and
// line wrap. Depends on b64_pkg, b64_if, b64_front, b64_queue, b64_back.
//
// Usage:
//   byte_ch carries one raw byte per item with last_byte marking the end of
//   a message. char_ch carries one character per item; run_end flags the
//   last character caused by a byte, stream_end the final one of a message.
//   The config port writes registers 0..3 (symbol 62, symbol 63, pad char,
//   line length) on any edge with cfg_we high; write only while idle.
// Timing:
//   A byte is accepted in the cycle the front classifies it and enters the
//   job queue at that edge; the output register then loads its first
//   character from the queue head and presents it on char_ch. The back end
//   emits one character per cycle while char_ch is not stalled, and a byte
//   makes 1 to 5 characters, about 4/3 per byte on a long message plus
//   newlines; the single output register sets that rate.
//   The front keeps taking bytes while the queue (QUEUE_DEPTH jobs) has room.
// Reset: clears the queue, the output stage, the group state and restores
//   the default alphabet, pad and no line breaks.
// Stall: when the receiver holds ready low the output item holds, the queue
//   fills and byte_ch.ready drops.
`timescale 1ns / 1ps

module base64_stream_encoder_top import b64_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	b64_byte_if.sink              byte_ch,
	b64_char_if.source            char_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic job_valid;
	logic job_ready;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.char_62     <= RST_CHAR_62;
			cfg_q.char_63     <= RST_CHAR_63;
			cfg_q.pad_char    <= RST_PAD_CHAR;
			cfg_q.line_length <= RST_LINE_LEN;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHAR_62:  cfg_q.char_62     <= cfg_wdata[BYTE_W-1:0];
				CFG_CHAR_63:  cfg_q.char_63     <= cfg_wdata[BYTE_W-1:0];
				CFG_PAD_CHAR: cfg_q.pad_char    <= cfg_wdata[BYTE_W-1:0];
				CFG_LINE_LEN: cfg_q.line_length <= cfg_wdata[COL_W-1:0];
				default:      cfg_q             <= cfg_q;
			endcase
		end
	end

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.cfg       (cfg_q),
		.job_ready (job_ready),
		.job_valid (job_valid),
		.job       (job)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_job   (job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.char_ch    (char_ch)
	);

endmodule

[src/b64_front.sv]
// b64_front: accepts raw bytes, keeps group phase, carry bits and line column,
// and turns each byte into one job of up to five characters. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_front import b64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64_byte_if.sink    byte_ch,
	input  cfg_t        cfg,
	input  logic        job_ready,
	output logic        job_valid,
	output job_t        job
);

	phase_t             phase_q;
	logic [3:0]         carry_q;
	logic [COL_W-1:0]   col_q;
	logic               bp_q;

	logic               accept;
	logic               newline;
	logic [3:0][BYTE_W-1:0] d;
	logic [JOB_CNT_W-1:0] dn;
	logic [BYTE_W-1:0]  b;
	logic               last;
	logic [COL_W:0]     col_sum;
	logic [COL_W-1:0]   col_new;
	phase_t             phase_nx;
	logic [3:0]         carry_nx;
	logic               bp_nx;

	assign byte_ch.ready = job_ready;
	assign accept        = byte_ch.valid & job_ready;
	assign job_valid     = byte_ch.valid;
	assign b             = byte_ch.data_byte;
	assign last          = byte_ch.last_byte;

	always_comb begin
		d        = '0;
		dn       = '0;
		newline  = 1'b0;
		phase_nx = PH_0;
		carry_nx = '0;
		case (phase_q)
			PH_1: begin
				d[0]     = sextet_char({carry_q[1:0], b[7:4]}, cfg.char_62, cfg.char_63);
				d[1]     = sextet_char({b[3:0], 2'b00}, cfg.char_62, cfg.char_63);
				d[2]     = cfg.pad_char;
				dn       = last ? 3'd3 : 3'd1;
				phase_nx = PH_2;
				carry_nx = b[3:0];
			end
			PH_2: begin
				d[0]     = sextet_char({carry_q, b[7:6]}, cfg.char_62, cfg.char_63);
				d[1]     = sextet_char(b[5:0], cfg.char_62, cfg.char_63);
				dn       = 3'd2;
				phase_nx = PH_0;
			end
			default: begin
				newline  = bp_q;
				d[0]     = sextet_char(b[7:2], cfg.char_62, cfg.char_63);
				d[1]     = sextet_char({b[1:0], 4'b0000}, cfg.char_62, cfg.char_63);
				d[2]     = cfg.pad_char;
				d[3]     = cfg.pad_char;
				dn       = last ? 3'd4 : 3'd1;
				phase_nx = PH_1;
				carry_nx = {2'b00, b[1:0]};
			end
		endcase

		// column restarts after an owed newline; saturate at the top
		col_sum = (newline ? '0 : {1'b0, col_q}) + {{(COL_W + 1 - JOB_CNT_W){1'b0}}, dn};
		col_new = (col_sum > {1'b0, COLUMN_MAX}) ? COLUMN_MAX : col_sum[COL_W-1:0];

		if (phase_q == PH_2) begin
			bp_nx = (cfg.line_length != '0) && (col_new >= cfg.line_length);
		end else begin
			bp_nx = newline ? 1'b0 : bp_q;
		end

		job.last = last;
		job.cnt  = dn + {{(JOB_CNT_W-1){1'b0}}, newline};
		if (newline) begin
			job.chars = {d, NEWLINE_CHAR};
		end else begin
			job.chars = {NEWLINE_CHAR, d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= '0;
			col_q   <= '0;
			bp_q    <= 1'b0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_0;
				carry_q <= '0;
				col_q   <= '0;
				bp_q    <= 1'b0;
			end else begin
				phase_q <= phase_nx;
				carry_q <= carry_nx;
				col_q   <= col_new;
				bp_q    <= bp_nx;
			end
		end
	end

endmodule

[src/b64_queue.sv]
// b64_queue: short job queue between front and back so each side can stall
// on its own. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_queue import b64_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic head_valid,
	input  logic pop,
	output job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/b64_back.sv]
// b64_back: walks the head job one character per cycle, while the output is not
// stalled, into a registered output stage. Depends on b64_pkg and b64_char_if.
`timescale 1ns / 1ps

module b64_back import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	b64_char_if.source char_ch
);

	logic [JOB_CNT_W-1:0] idx_q;
	logic                 ov_q;
	logic [BYTE_W-1:0]    och_q;
	logic                 orun_q;
	logic                 oend_q;
	logic                 load;
	logic                 is_final;

	assign load     = head_valid & (~ov_q | char_ch.ready);
	assign is_final = (idx_q == head_job.cnt - 1'b1);
	assign pop      = load & is_final;

	assign char_ch.valid      = ov_q;
	assign char_ch.out_char   = och_q;
	assign char_ch.run_end    = orun_q;
	assign char_ch.stream_end = oend_q;

	always_ff @(posedge clk) begin
		if (load) begin
			och_q  <= head_job.chars[idx_q];
			orun_q <= is_final;
			oend_q <= is_final & head_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_final ? '0 : idx_q + 1'b1;
			end else if (char_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

[src/b64_checker.sv]
// b64_checker: port-level assertions for the Base64 stream encoder, bound to
// the top level. Depends on base64_stream_encoder_top and b64_pkg.
`timescale 1ns / 1ps

module b64_checker import b64_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_char,
	input logic              out_run_end,
	input logic              out_stream_end
);

	// a stalled character holds with its flags
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(out_run_end) && $stable(out_stream_end))
		else $error("output item changed while stalled");

	// the end of a message is always the end of a byte's run
	a_end_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stream_end |-> out_run_end)
		else $error("stream_end without run_end");

	// output stays idle in the cycle after an edge seen in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");

endmodule

bind base64_stream_encoder_top b64_checker u_b64_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (char_ch.valid),
	.out_ready      (char_ch.ready),
	.out_char       (char_ch.out_char),
	.out_run_end    (char_ch.run_end),
	.out_stream_end (char_ch.stream_end)
);

[bench/base64_stream_encoder_top_test.sv]
// base64_stream_encoder_top_test: self-checking bench for the Base64 stream encoder.
// Drives byte items with random gaps, predicts every character and compares it
// against char_ch. Depends on b64_pkg, b64_if and base64_stream_encoder_top.
`timescale 1ns / 1ps

module base64_stream_encoder_top_test;
	import b64_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 31;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} raw_byte_t;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              run_end;
		logic              stream_end;
	} enc_char_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  byte_valid = 1'b0;
	logic [BYTE_W-1:0]     byte_data  = '0;
	logic                  byte_last  = 1'b0;
	logic                  char_ready = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

	b64_byte_if byte_ch ();
	b64_char_if char_ch ();

	assign byte_ch.valid     = byte_valid;
	assign byte_ch.data_byte = byte_data;
	assign byte_ch.last_byte = byte_last;
	assign char_ch.ready     = char_ready;

	base64_stream_encoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.char_ch   (char_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	raw_byte_t byte_backlog [$];
	enc_char_t expected_chars [$];
	bit        byte_done;
	bit        calm;
	int        error_count;
	int        cycle_count;

	// Encoder state and register copies as the block should hold them.
	string             std_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
	logic [BYTE_W-1:0] sym_62   = RST_CHAR_62;
	logic [BYTE_W-1:0] sym_63   = RST_CHAR_63;
	logic [BYTE_W-1:0] pad_sym  = RST_PAD_CHAR;
	logic [COL_W-1:0]  line_len = RST_LINE_LEN;
	phase_t            grp_phase = PH_0;
	logic [3:0]        carry    = '0;
	logic [COL_W-1:0]  line_col = '0;
	logic              newline_owed = 1'b0;

	function automatic logic [BYTE_W-1:0] sextet_to_char(input logic [5:0] v);
		if (v == 6'd62)
			return sym_62;
		if (v == 6'd63)
			return sym_63;
		return std_alphabet[v];
	endfunction

	function automatic void bump_col();
		if (line_col < COLUMN_MAX)
			line_col = line_col + 1'b1;
	endfunction

	// Work out every character one accepted byte causes and advance the state.
	function automatic void encode_byte(input raw_byte_t it);
		logic [BYTE_W-1:0] chars [$];
		enc_char_t         r;
		if (grp_phase == PH_0 && newline_owed) begin
			chars.push_back(NEWLINE_CHAR);
			line_col = '0;
			newline_owed = 1'b0;
		end
		case (grp_phase)
			PH_0: begin
				chars.push_back(sextet_to_char(it.data[7:2]));
				bump_col();
				carry = {2'b00, it.data[1:0]};
				grp_phase = PH_1;
				if (it.last) begin
					chars.push_back(sextet_to_char({it.data[1:0], 4'b0000}));
					bump_col();
					chars.push_back(pad_sym);
					bump_col();
					chars.push_back(pad_sym);
					bump_col();
				end
			end
			PH_1: begin
				chars.push_back(sextet_to_char({carry[1:0], it.data[7:4]}));
				bump_col();
				carry = it.data[3:0];
				grp_phase = PH_2;
				if (it.last) begin
					chars.push_back(sextet_to_char({it.data[3:0], 2'b00}));
					bump_col();
					chars.push_back(pad_sym);
					bump_col();
				end
			end
			default: begin
				chars.push_back(sextet_to_char({carry, it.data[7:6]}));
				bump_col();
				chars.push_back(sextet_to_char(it.data[5:0]));
				bump_col();
				carry = '0;
				grp_phase = PH_0;
				// line length is only checked when a group completes
				if (!it.last && line_len != '0 && line_col >= line_len)
					newline_owed = 1'b1;
			end
		endcase
		foreach (chars[i]) begin
			r.ch         = chars[i];
			r.run_end    = (i == chars.size() - 1);
			r.stream_end = it.last && (i == chars.size() - 1);
			expected_chars.push_back(r);
		end
		if (it.last) begin
			grp_phase = PH_0;
			carry = '0;
			line_col = '0;
			newline_owed = 1'b0;
		end
	endfunction

	// Byte side: record acceptance, then offer the next item at the falling edge.
	always @(posedge clk) begin
		if (arst_n && byte_valid && byte_ch.ready) begin
			encode_byte(byte_backlog.pop_front());
			byte_done = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_done = 1'b0;
		end else if (!byte_valid || byte_done) begin
			byte_done = 1'b0;
			if (byte_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				byte_valid <= 1'b1;
				byte_data  <= byte_backlog[0].data;
				byte_last  <= byte_backlog[0].last;
			end else begin
				byte_valid <= 1'b0;
				byte_data  <= 8'($urandom_range(255));
				byte_last  <= 1'($urandom_range(1));
			end
		end
	end

	// Character side: random backpressure, compare each accepted item.
	always @(negedge clk) begin
		if (!arst_n)
			char_ready <= 1'b0;
		else
			char_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		enc_char_t want;
		if (arst_n && char_ch.valid && char_ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char expected none got %02h run_end %b stream_end %b",
					$time, char_ch.out_char, char_ch.run_end, char_ch.stream_end);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (char_ch.out_char !== want.ch) begin
					$display("%0t: out_char expected %02h got %02h",
						$time, want.ch, char_ch.out_char);
					error_count++;
				end
				if (char_ch.run_end !== want.run_end) begin
					$display("%0t: run_end expected %b got %b",
						$time, want.run_end, char_ch.run_end);
					error_count++;
				end
				if (char_ch.stream_end !== want.stream_end) begin
					$display("%0t: stream_end expected %b got %b",
						$time, want.stream_end, char_ch.stream_end);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] d, input logic l);
		raw_byte_t it;
		it.data = d;
		it.last = l;
		byte_backlog.push_back(it);
	endtask

	task automatic queue_message(input int count, input bit terminate);
		logic [BYTE_W-1:0] d;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: d = 8'h00;
				1: d = 8'hFF;
				default: d = 8'($urandom_range(255));
			endcase
			push_byte(d, terminate && (i == count - 1));
		end
	endtask

	// Hold until every item is in and every character is out, then settle.
	task automatic wait_idle();
		while (byte_backlog.size() != 0 || byte_valid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_CHAR_62:  sym_62   = value[BYTE_W-1:0];
			CFG_CHAR_63:  sym_63   = value[BYTE_W-1:0];
			CFG_PAD_CHAR: pad_sym  = value[BYTE_W-1:0];
			default:      line_len = value[COL_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_symbol();
		logic [BYTE_W-1:0] c;
		case ($urandom_range(3))
			0: c = 8'h00;
			1: c = 8'hFF;
			default: c = 8'($urandom_range(255));
		endcase
		// upper bits of the write data are don't-care for byte registers
		return {2'($urandom_range(3)), c};
	endfunction

	initial begin
		int items;
		int len;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Defaults: single byte with two pads, two bytes with one pad, symbols 62/63.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b1);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFE, 1'b1);
		wait_idle();

		// Shortest line: newline between groups, none after the final group.
		write_reg(CFG_CHAR_62, {2'b11, 8'h00});
		write_reg(CFG_CHAR_63, 10'h0FF);
		write_reg(CFG_PAD_CHAR, {2'b10, 8'h00});
		write_reg(CFG_LINE_LEN, 10'd1);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h7F, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h83, 1'b1);
		// leave a newline owed across the register change below
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hC3, 1'b0);
		wait_idle();

		write_reg(CFG_CHAR_62, 10'h0FF);
		write_reg(CFG_CHAR_63, 10'h000);
		write_reg(CFG_PAD_CHAR, 10'h3FF);
		write_reg(CFG_LINE_LEN, 10'd0);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// Longer message on a line length that is not a group multiple.
		write_reg(CFG_CHAR_62, {2'b00, RST_CHAR_62});
		write_reg(CFG_CHAR_63, {2'b00, RST_CHAR_63});
		write_reg(CFG_PAD_CHAR, {2'b00, RST_PAD_CHAR});
		write_reg(CFG_LINE_LEN, 10'd30);
		queue_message(40, 1'b1);
		wait_idle();

		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_CHAR_62, pick_symbol());
			write_reg(CFG_CHAR_63, pick_symbol());
			write_reg(CFG_PAD_CHAR, pick_symbol());
			case ($urandom_range(5))
				0: write_reg(CFG_LINE_LEN, 10'd0);
				1: write_reg(CFG_LINE_LEN, 10'd1);
				2: write_reg(CFG_LINE_LEN, 10'd1023);
				default: write_reg(CFG_LINE_LEN, 10'($urandom_range(2, 20)));
			endcase
			calm = (p == 2);
			items = 0;
			while (items < 36) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
				// an open message now and then carries into the next setting
				queue_message(len, $urandom_range(7) != 0);
				items += len;
			end
			wait_idle();
		end
		calm = 1'b0;

		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
